// ----- rtl/slfr_pkg.sv -----
// Package for the sync/length frame receiver: byte and status codes, FSM type.
// No dependencies.
`timescale 1ns / 1ps

package slfr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    // result status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_status;

    typedef enum logic [4:0] {
        S_HUNT = 5'b00001,
        S_LEN  = 5'b00010,
        S_DATA = 5'b00100,
        S_RD   = 5'b01000,
        S_LD   = 5'b10000
    } t_state;

endpackage

// ----- rtl/slfr_rx_if.sv -----
// Receive byte channel: valid/ready handshake plus one received byte.
// Depends on slfr_pkg.
`timescale 1ns / 1ps

interface slfr_rx_if;
    logic            valid;
    logic            ready;
    slfr_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/slfr_res_if.sv -----
// Result channel: valid/ready handshake plus payload byte, last mark and status.
// Depends on slfr_pkg.
`timescale 1ns / 1ps

interface slfr_res_if;
    logic              valid;
    logic              ready;
    slfr_pkg::t_byte   payload_byte;
    logic              last;
    slfr_pkg::t_status status;

    modport source (output valid, output payload_byte, output last, output status,
                    input ready);
    modport sink   (input valid, input payload_byte, input last, input status,
                    output ready);
endinterface

// ----- rtl/slfr_store.sv -----
// Frame byte store: simple dual-port RAM, one write and one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module slfr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sync_length_frame_receiver.sv -----
// Sync/length/checksum frame receiver, top level. Depends on slfr_pkg,
// slfr_rx_if, slfr_res_if and slfr_store.
// A status result (empty frame, bad sum) is registered as the checksum byte is taken; the first
// payload byte follows through S_RD and S_LD. Input bytes are taken while not draining.
// A good frame of length L drains L-1 payload bytes, each by a store read (S_RD) and then an
// output load (S_LD), and the receive side is held off until the drain ends.
// Reset (i_rst_n, synchronous, active low) returns to hunting and empties the output
// register; the frame store is not cleared, every byte read is written first in the frame.
`timescale 1ns / 1ps

module sync_length_frame_receiver #(
    parameter int MAX_FRAME = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slfr_rx_if.sink     i_rx,
    slfr_res_if.source  o_res
);

    import slfr_pkg::*;

    // length/count width holds MAX_FRAME itself; address width indexes the store
    localparam int LEN_W = $clog2(MAX_FRAME + 1);
    localparam int AW    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state           r_state,   n_state;
    logic [LEN_W-1:0] r_len,     n_len;     // frame length L
    logic [LEN_W-1:0] r_fill,    n_fill;    // bytes stored so far
    logic [7:0]       r_sum,     n_sum;     // wrapping sum of the payload bytes
    logic [AW-1:0]    r_rd_idx,  n_rd_idx;  // drain pointer

    // output register, parts the receive side from the result consumer
    logic             r_out_valid, n_out_valid;
    t_byte            r_out_byte,  n_out_byte;
    logic             r_out_last,  n_out_last;
    t_status          r_out_status, n_out_status;

    logic             out_free;
    logic             rx_fire;
    logic             len_bad;
    logic [LEN_W-1:0] fill_inc;
    logic             drain_last;

    logic             wr_en;
    logic             rd_en;
    logic [7:0]       rd_data;

    // ---------------------------------------------------------------
    // Frame store
    // Writes happen only in S_DATA, reads only while draining, so the
    // two ports never touch the same entry in the same cycle. The checksum
    // write lands at L-1, never at the first read address 0 (L >= 2).
    // ---------------------------------------------------------------
    slfr_store #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_rx.rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign out_free   = !r_out_valid || o_res.ready;
    // take a byte whenever not draining and the output register can absorb
    // a possible status result
    assign i_rx.ready = ((r_state == S_HUNT) || (r_state == S_LEN) || (r_state == S_DATA))
                        && out_free;
    assign rx_fire    = i_rx.valid && i_rx.ready;

    assign len_bad    = (i_rx.rx_byte == 8'd0) ||
                        ({1'b0, i_rx.rx_byte} > 9'(MAX_FRAME));
    assign fill_inc   = r_fill + LEN_W'(1);
    // final payload byte sits at index L-2
    assign drain_last = (LEN_W'(r_rd_idx) + LEN_W'(1)) == (r_len - LEN_W'(1));

    assign wr_en      = rx_fire && (r_state == S_DATA);
    assign rd_en      = (r_state == S_RD);

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_HUNT: begin
                if (rx_fire && (i_rx.rx_byte == SYNC_BYTE)) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (rx_fire) begin
                    n_fill = '0;
                    n_sum  = '0;
                    if (len_bad) begin
                        n_state = S_HUNT;
                        n_len   = '0;
                    end else begin
                        n_state = S_DATA;
                        n_len   = LEN_W'(i_rx.rx_byte);
                    end
                end
            end
            S_DATA: begin
                if (rx_fire) begin
                    n_fill = fill_inc;
                    if (fill_inc < r_len) begin
                        n_sum = r_sum + i_rx.rx_byte;
                    end else begin
                        // checksum byte
                        n_rd_idx = '0;
                        if (r_sum != i_rx.rx_byte) begin
                            n_out_valid  = 1'b1;
                            n_out_byte   = '0;
                            n_out_last   = 1'b1;
                            n_out_status = ST_BAD;
                            n_state      = S_HUNT;
                        end else if (r_len == LEN_W'(1)) begin
                            n_out_valid  = 1'b1;
                            n_out_byte   = '0;
                            n_out_last   = 1'b1;
                            n_out_status = ST_EMPTY;
                            n_state      = S_HUNT;
                        end else begin
                            n_state = S_RD;
                        end
                        if (n_state == S_HUNT) begin
                            n_len  = '0;
                            n_fill = '0;
                            n_sum  = '0;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                // read data is held in the store until the next read
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = rd_data;
                    n_out_last   = drain_last;
                    n_out_status = ST_BYTE;
                    if (drain_last) begin
                        n_state = S_HUNT;
                        n_len   = '0;
                        n_fill  = '0;
                        n_sum   = '0;
                    end else begin
                        n_state  = S_RD;
                        n_rd_idx = r_rd_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT;
            r_len       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.last         = r_out_last;
    assign o_res.status       = r_out_status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_rx_while_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_LD)) |-> !i_rx.ready)
        else $error("receive side open while draining");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_BYTE)) |-> (r_out_last && (r_out_byte == 8'd0)))
        else $error("status-only result without last mark or with data");

    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> ((r_fill < r_len) && (r_len != '0)))
        else $error("fill index outside frame length");

    a_drain_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) && ($past(r_state) == S_DATA)) |-> (r_rd_idx == '0))
        else $error("drain did not start at entry zero");

endmodule

// ----- test/tb_sync_length_frame_receiver.sv -----
// Self-checking testbench for sync_length_frame_receiver: directed frame table, then random
// frames under several idle/stall mixes. Depends on slfr_pkg, slfr_rx_if, slfr_res_if.
`timescale 1ns / 1ps

module tb_sync_length_frame_receiver;
    import slfr_pkg::*;

    localparam int FRAME_CAP    = 64;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 2 * (FRAME_CAP - 1) + 24;
    localparam int RAND_PER_PH  = 28;
    localparam int PRESS_HOLD   = 300;

    typedef enum logic [1:0] {HUNTING, WANT_LEN, STORING} t_rx_phase;
    typedef enum logic [2:0] {FILL_ZERO, FILL_ONES, FILL_SYNC, FILL_RAMP, FILL_RAND} t_fill;

    typedef struct packed {
        t_byte   data;
        logic    last;
        t_status status;
    } t_result;

    // one received byte; a hand-typed expectation may ride on the byte that ends a row
    typedef struct packed {
        t_byte   b;
        bit      typed;
        bit      t_res;
        t_status t_st;
    } t_rx_item;

    typedef struct packed {
        logic [1:0] noise;
        t_byte      len_b;
        t_fill      fill;
        t_byte      flip;
        bit         typed;
        bit         t_res;
        t_status    t_st;
    } t_dir_row;

    // typed rows carry the one status result (or none) that the frame must give
    localparam t_dir_row DIR_ROWS [15] = '{
        '{2'd3, 8'd1,   FILL_ZERO, 8'h00, 1'b1, 1'b1, ST_EMPTY}, // noise, then empty frame
        '{2'd0, 8'd1,   FILL_ZERO, 8'h01, 1'b1, 1'b1, ST_BAD},
        '{2'd0, 8'd1,   FILL_ZERO, 8'hAA, 1'b1, 1'b1, ST_BAD},   // sync value as checksum
        '{2'd0, 8'd0,   FILL_ZERO, 8'h00, 1'b1, 1'b0, ST_BYTE},  // zero length dropped
        '{2'd0, 8'd65,  FILL_ZERO, 8'h00, 1'b1, 1'b0, ST_BYTE},  // one over the store size
        '{2'd0, 8'd255, FILL_ZERO, 8'h00, 1'b1, 1'b0, ST_BYTE},
        '{2'd0, 8'hAA,  FILL_ZERO, 8'h00, 1'b1, 1'b0, ST_BYTE},  // back-to-back sync
        '{2'd0, 8'd2,   FILL_ONES, 8'h00, 1'b0, 1'b0, ST_BYTE},
        '{2'd0, 8'd2,   FILL_ZERO, 8'h00, 1'b0, 1'b0, ST_BYTE},
        '{2'd0, 8'd4,   FILL_SYNC, 8'h00, 1'b0, 1'b0, ST_BYTE},  // sync bytes inside a frame
        '{2'd1, 8'd64,  FILL_RAMP, 8'h00, 1'b0, 1'b0, ST_BYTE},  // full store
        '{2'd0, 8'd64,  FILL_RAND, 8'h80, 1'b1, 1'b1, ST_BAD},
        '{2'd0, 8'd3,   FILL_ONES, 8'hFF, 1'b1, 1'b1, ST_BAD},
        '{2'd0, 8'd63,  FILL_RAND, 8'h00, 1'b0, 1'b0, ST_BYTE},
        '{2'd0, 8'd9,   FILL_RAND, 8'h00, 1'b0, 1'b0, ST_BYTE}
    };

    logic i_clk;
    logic i_rst_n;

    slfr_rx_if  rx_if ();
    slfr_res_if res_if ();

    sync_length_frame_receiver #(.MAX_FRAME(FRAME_CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // predicted deframer state
    t_rx_phase   m_phase;
    logic [6:0]  m_len;
    logic [6:0]  m_fill;
    t_byte       m_sum;
    t_byte       m_store [FRAME_CAP];

    t_result     step_res[$];   // results caused by the latest byte
    t_result     released_q[$]; // results the block still owes
    t_rx_item    byte_q[$];     // bytes waiting to be offered

    int  tx_idle_pct;
    int  rx_stall_pct;
    int  hold_req;
    bit  tx_busy;
    int  n_queued;
    int  n_rx, n_res, n_fail;
    int  n_good, n_empty, n_bad, n_payload;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void go_hunt();
        m_phase = HUNTING;
        m_len   = '0;
        m_fill  = '0;
        m_sum   = '0;
    endfunction

    // deframe one received byte, leaving its results in step_res
    function automatic void deframe_byte(input t_byte b);
        t_result r;
        int      i;
        step_res.delete();
        case (m_phase)
            WANT_LEN: begin
                if (b == 8'd0 || int'(b) > FRAME_CAP) begin
                    go_hunt();
                end else begin
                    m_len   = b[6:0];
                    m_fill  = '0;
                    m_sum   = '0;
                    m_phase = STORING;
                end
            end
            STORING: begin
                if (int'(m_fill) < FRAME_CAP) m_store[m_fill[5:0]] = b;
                m_fill = m_fill + 7'd1;
                if (m_fill < m_len) begin
                    m_sum = m_sum + b;
                end else begin
                    if (m_sum != b) begin
                        r = '{data: 8'h00, last: 1'b1, status: ST_BAD};
                        step_res.push_back(r);
                    end else if (m_len <= 7'd1) begin
                        r = '{data: 8'h00, last: 1'b1, status: ST_EMPTY};
                        step_res.push_back(r);
                    end else begin
                        for (i = 0; i < int'(m_len) - 1; i++) begin
                            r = '{data: m_store[i], last: (i == int'(m_len) - 2),
                                  status: ST_BYTE};
                            step_res.push_back(r);
                        end
                    end
                    go_hunt();
                end
            end
            default: begin
                if (b == SYNC_BYTE) m_phase = WANT_LEN;
                else go_hunt();
            end
        endcase
    endfunction

    function automatic void take_byte(input t_rx_item it);
        t_result r;
        deframe_byte(it.b);
        if (it.typed) begin
            if (it.t_res) begin
                r = '{data: 8'h00, last: 1'b1, status: it.t_st};
                released_q.push_back(r);
            end
        end else begin
            foreach (step_res[k]) released_q.push_back(step_res[k]);
        end
    endfunction

    function automatic void check_res(input t_byte d, input logic l, input t_status s);
        t_result e;
        if (released_q.size() == 0) begin
            $error("unexpected result: payload_byte %02h last %0d status %0d", d, l, s);
            n_fail++;
        end else begin
            e = released_q.pop_front();
            if (e.data !== d) begin
                $error("payload_byte: expected %02h, actual %02h", e.data, d);
                n_fail++;
            end
            if (e.last !== l) begin
                $error("last: expected %0d, actual %0d", e.last, l);
                n_fail++;
            end
            if (e.status !== s) begin
                $error("status: expected %0d, actual %0d", e.status, s);
                n_fail++;
            end
        end
        if (s == ST_BYTE) n_payload++;
        if (s == ST_BYTE && l) n_good++;
        if (s == ST_EMPTY) n_empty++;
        if (s == ST_BAD) n_bad++;
    endfunction

    function automatic void push_item(input t_byte b, input bit typed, input bit t_res,
                                      input t_status t_st);
        t_rx_item it;
        it = '{b: b, typed: typed, t_res: t_res, t_st: t_st};
        byte_q.push_back(it);
        n_queued++;
    endfunction

    // bytes the hunter skips; never the sync value
    function automatic void push_noise(input int n);
        t_rx_item it;
        int       i;
        for (i = 0; i < n; i++) begin
            it = '{b: t_byte'($urandom), typed: 1'b0, t_res: 1'b0, t_st: ST_BYTE};
            if (it.b == SYNC_BYTE) it.b = 8'h55;
            byte_q.push_back(it);
        end
    endfunction

    // sync, length, and for a legal length the payload plus checksum (xor flip)
    function automatic void push_frame(input t_byte len_b, input t_fill fill, input t_byte flip,
                                       input bit typed, input bit t_res, input t_status t_st);
        t_byte d;
        t_byte sum;
        int    i;
        bit    ok;
        ok = (len_b != 8'd0) && (int'(len_b) <= FRAME_CAP);
        push_item(SYNC_BYTE, 1'b0, 1'b0, ST_BYTE);
        push_item(len_b, typed && !ok, t_res, t_st);
        if (ok) begin
            sum = '0;
            for (i = 0; i < int'(len_b) - 1; i++) begin
                case (fill)
                    FILL_ZERO: d = 8'h00;
                    FILL_ONES: d = 8'hFF;
                    FILL_SYNC: d = SYNC_BYTE;
                    FILL_RAMP: d = t_byte'(i);
                    default:   d = ($urandom_range(7) == 0) ? SYNC_BYTE : t_byte'($urandom);
                endcase
                sum = sum + d;
                push_item(d, 1'b0, 1'b0, ST_BYTE);
            end
            push_item(sum ^ flip, typed, t_res, t_st);
        end
    endfunction

    // mostly short frames, some mid-size, a few full
    function automatic t_byte rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 6) return t_byte'(FRAME_CAP);
        if (r < 20) return t_byte'($urandom_range(FRAME_CAP - 1, 9));
        return t_byte'($urandom_range(8, 1));
    endfunction

    function automatic void push_random();
        int    r;
        int    k;
        t_byte len_b;
        r = $urandom_range(99);
        if (r < 70) begin
            push_frame(rand_len(), FILL_RAND, 8'h00, 1'b0, 1'b0, ST_BYTE);
        end else if (r < 80) begin
            push_frame(rand_len(), FILL_RAND, t_byte'($urandom_range(255, 1)),
                       1'b0, 1'b0, ST_BYTE);
        end else if (r < 85) begin
            len_b = $urandom_range(1) ? 8'd0 : t_byte'($urandom_range(255, FRAME_CAP + 1));
            push_frame(len_b, FILL_RAND, 8'h00, 1'b0, 1'b0, ST_BYTE);
        end else if (r < 92) begin
            // broken frame: cut short, so whatever follows is taken as its data
            len_b = t_byte'($urandom_range(FRAME_CAP, 2));
            push_item(SYNC_BYTE, 1'b0, 1'b0, ST_BYTE);
            push_item(len_b, 1'b0, 1'b0, ST_BYTE);
            for (k = $urandom_range(int'(len_b) - 2); k > 0; k--)
                push_item(t_byte'($urandom), 1'b0, 1'b0, ST_BYTE);
        end else begin
            push_noise($urandom_range(3, 1));
        end
    endfunction

    task automatic wait_sent();
        while (byte_q.size() != 0 || tx_busy) @(posedge i_clk);
    endtask

    // byte source: holds valid until the transaction, idles only between bytes
    initial begin : rx_source
        t_rx_item cur;
        cur = '0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rx_if.valid && rx_if.ready) begin
                take_byte(cur);
                n_rx++;
                tx_busy = 1'b0;
            end
            if (i_rst_n && !tx_busy && byte_q.size() != 0 &&
                    $urandom_range(99) >= tx_idle_pct) begin
                cur     = byte_q.pop_front();
                tx_busy = 1'b1;
            end
            rx_if.valid   <= tx_busy;
            rx_if.rx_byte <= tx_busy ? cur.b : t_byte'($urandom);
        end
    end

    // result sink: random stalls, plus a long hold-off on request
    initial begin : res_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                check_res(res_if.payload_byte, res_if.last, res_if.status);
                n_res++;
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        int seen_rx;
        int seen_res;
        quiet    = 0;
        seen_rx  = 0;
        seen_res = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (n_rx != seen_rx || n_res != seen_res) quiet = 0;
            else quiet++;
            seen_rx  = n_rx;
            seen_res = n_res;
        end
        $display("FAIL sync_length_frame_receiver");
        $finish;
    end

    initial begin : main_seq
        int p;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_req      = 0;
        tx_busy       = 1'b0;
        n_queued      = 0;
        n_rx = 0; n_res = 0; n_fail = 0;
        n_good = 0; n_empty = 0; n_bad = 0; n_payload = 0;
        go_hunt();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            push_noise(DIR_ROWS[r].noise);
            push_frame(DIR_ROWS[r].len_b, DIR_ROWS[r].fill, DIR_ROWS[r].flip,
                       DIR_ROWS[r].typed, DIR_ROWS[r].t_res, DIR_ROWS[r].t_st);
        end
        wait_sent();

        for (p = 0; p < 4; p++) begin
            case (p)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            n_queued = 0;
            while (n_queued < RAND_PER_PH) push_random();
            wait_sent();
        end

        // back-pressure: a full frame and a short one queued while results are held off
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        push_frame(t_byte'(FRAME_CAP), FILL_RAND, 8'h00, 1'b0, 1'b0, ST_BYTE);
        push_frame(8'd10, FILL_RAND, 8'h00, 1'b0, 1'b0, ST_BYTE);
        hold_req = PRESS_HOLD;
        wait_sent();

        while (released_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d bytes received, %0d results checked, %0d mismatches",
                 n_rx, n_res, n_fail);
        $display("Frames: %0d good (%0d payload bytes), %0d empty, %0d checksum errors",
                 n_good, n_payload, n_empty, n_bad);
        if (n_fail == 0 && released_q.size() == 0) begin
            $display("PASS sync_length_frame_receiver");
        end else begin
            $display("FAIL sync_length_frame_receiver");
        end
        $finish;
    end

endmodule
